// File: rtl/core/kwtok_pkg.sv
// Shared types, token codes, keyword tables and helper functions for the keyword tokenizer.
`timescale 1ns / 1ps

package kwtok_pkg;

  // Default widths of the position and line counters
  localparam int POSITION_BITS_DEF = 32;
  localparam int LINE_BITS_DEF     = 32;

  // Result field widths
  localparam int KIND_W      = 4;
  localparam int TEXT_W      = 32;
  localparam int OUT_FIELDS_W = KIND_W + 3 * TEXT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // Scanner modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_STRING = 2'd1;
  localparam logic [1:0] MODE_IDENT  = 2'd2;

  // Token kinds
  localparam logic [KIND_W-1:0] KIND_END      = 4'd0;
  localparam logic [KIND_W-1:0] KIND_LPAREN   = 4'd1;
  localparam logic [KIND_W-1:0] KIND_RPAREN   = 4'd2;
  localparam logic [KIND_W-1:0] KIND_LBRACE   = 4'd3;
  localparam logic [KIND_W-1:0] KIND_RBRACE   = 4'd4;
  localparam logic [KIND_W-1:0] KIND_STRING   = 4'd5;
  localparam logic [KIND_W-1:0] KIND_IDENT    = 4'd6;
  localparam logic [KIND_W-1:0] KIND_KW_FIRST = 4'd7;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 4'd11;

  // Special characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Keywords: print, input, function, public
  localparam int NUM_KW = 4;
  localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
    '{"p", "r", "i", "n", "t", 8'h00, 8'h00, 8'h00},
    '{"i", "n", "p", "u", "t", 8'h00, 8'h00, 8'h00},
    '{"f", "u", "n", "c", "t", "i", "o", "n"},
    '{"p", "u", "b", "l", "i", "c", 8'h00, 8'h00}
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd5, 4'd5, 4'd8, 4'd6};

  typedef struct packed {
    logic              last;
    logic [TEXT_W-1:0] line;
    logic [TEXT_W-1:0] length;
    logic [TEXT_W-1:0] start;
    logic [KIND_W-1:0] kind;
  } tok_t;

  function automatic logic [TEXT_W-1:0] sat32(input logic [63:0] v);
    sat32 = (v[63:32] != 32'd0) ? {TEXT_W{1'b1}} : v[31:0];
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    is_letter = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= "0" && b <= "9");
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    is_space = (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  // Drop keywords that do not have byte b at offset i (i_ok: offset below 8)
  function automatic logic [NUM_KW-1:0] kw_narrow(input logic [NUM_KW-1:0] c,
                                                  input logic [2:0] i,
                                                  input logic i_ok,
                                                  input logic [7:0] b);
    logic [NUM_KW-1:0] r;
    r = c;
    for (int k = 0; k < NUM_KW; k++) begin
      if (!(i_ok && ({1'b0, i} < KW_LEN[k]) && (KW_TEXT[k][i] == b))) begin
        r[k] = 1'b0;
      end
    end
    kw_narrow = r;
  endfunction

  // Identifier kind from surviving candidates and length (len_ok: length below 16)
  function automatic logic [KIND_W-1:0] kw_kind(input logic [NUM_KW-1:0] c,
                                                input logic [3:0] len,
                                                input logic len_ok);
    logic [KIND_W-1:0] r;
    logic              hit;
    r   = KIND_IDENT;
    hit = 1'b0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (!hit && c[k] && len_ok && len == KW_LEN[k]) begin
        r   = KIND_KW_FIRST + KIND_W'(k);
        hit = 1'b1;
      end
    end
    kw_kind = r;
  endfunction

endpackage

// File: rtl/core/keyword_tokenizer_core.sv
// Keyword tokenizer top level: byte stream in, token stream out.
`timescale 1ns / 1ps

// Channel   | Dir | Payload                                              | Transfer
// ----------+-----+------------------------------------------------------+------------------
// s_axis    | in  | tdata[7:0] source_byte                               | tvalid && tready
// m_axis    | out | tdata kind[3:0] start[35:4] length[67:36]            | tvalid && tready
//           |     | line[99:68], zero pad above; tlast = last_of_run     |
//
// One source byte is taken per cycle. Its tokens, zero, one or two, are formed in the same
// cycle by the mode logic and written into a four-entry token queue; the queue head
// drives m_axis. Input is taken while the queue holds two tokens or fewer, so a byte
// that gives two tokens, or a stalled sink, is what slows the input side.
// Synchronous reset empties the queue and returns the scanner to idle, line 1.

module keyword_tokenizer_core #(
  parameter int POSITION_BITS = kwtok_pkg::POSITION_BITS_DEF,
  parameter int LINE_BITS     = kwtok_pkg::LINE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,   // source_byte
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // token_kind, text_start, text_length, token_line, zero pad
  output logic [kwtok_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                               m_axis_tlast    // last_of_run
);
  import kwtok_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX  = {POSITION_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]     LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]     LINE_ONE = LINE_BITS'(1);

  // Scanner state
  logic [1:0]               mode, mode_next;
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [POSITION_BITS-1:0] tok_begin, tok_begin_next;
  logic [LINE_BITS-1:0]     line_num, line_next;
  logic [NUM_KW-1:0]        cand, cand_next;

  // Token queue
  tok_t       fifo [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  logic [7:0]               b;
  logic [POSITION_BITS-1:0] pos_inc, idx;
  logic [LINE_BITS-1:0]     line_inc;
  logic                     idx_lt8, idx_lt16;
  logic                     run_idle;
  logic                     a_vld, b_vld;
  tok_t                     tok_a, tok_b;
  logic [1:0]               n_push;
  logic                     push, pop;
  tok_t                     head;

  assign b        = s_axis_tdata;
  assign pos_inc  = (pos == POS_MAX) ? pos : pos + POSITION_BITS'(1);
  assign line_inc = (b == CH_LF && line_num != LINE_MAX) ? line_num + LINE_ONE : line_num;
  // Offset into the open token; doubles as its length
  assign idx      = pos - tok_begin;
  assign idx_lt8  = (idx >> 3) == '0;
  assign idx_lt16 = (idx >> 4) == '0;

  always_comb begin
    mode_next      = mode;
    pos_next       = pos;
    line_next      = line_num;
    tok_begin_next = tok_begin;
    cand_next      = cand;
    a_vld          = 1'b0;
    b_vld          = 1'b0;
    run_idle       = 1'b0;
    // First token: closing a string or identifier
    tok_a = '{last: 1'b0, line: sat32(64'(line_num)), length: sat32(64'(idx)),
              start: sat32(64'(tok_begin)), kind: KIND_STRING};
    // Second token: whatever the byte gives in idle mode
    tok_b = '{last: 1'b0, line: sat32(64'(line_num)), length: '0,
              start: '0, kind: KIND_UNKNOWN};

    unique case (mode)
      MODE_STRING: begin
        if (b == CH_NUL) begin
          a_vld    = 1'b1;
          run_idle = 1'b1;
        end else if (b == CH_QUOTE) begin
          a_vld     = 1'b1;
          pos_next  = pos_inc;
          mode_next = MODE_IDLE;
        end else begin
          pos_next  = pos_inc;
          line_next = line_inc;   // newlines inside strings count
        end
      end
      MODE_IDENT: begin
        if (is_letter(b) || is_digit(b)) begin
          cand_next = kw_narrow(cand, idx[2:0], idx_lt8, b);
          pos_next  = pos_inc;
        end else begin
          a_vld      = 1'b1;
          tok_a.kind = kw_kind(cand, idx[3:0], idx_lt16);
          run_idle   = 1'b1;
        end
      end
      default: run_idle = 1'b1;
    endcase

    if (run_idle) begin
      mode_next = MODE_IDLE;
      priority if (b == CH_NUL) begin
        b_vld      = 1'b1;
        tok_b.kind = KIND_END;
        pos_next   = '0;
        line_next  = LINE_ONE;
        cand_next  = '1;
      end else if (is_space(b)) begin
        pos_next  = pos_inc;
        line_next = line_inc;
      end else if (b == CH_LPAREN || b == CH_RPAREN || b == CH_LBRACE || b == CH_RBRACE) begin
        b_vld    = 1'b1;
        pos_next = pos_inc;
        priority if (b == CH_LPAREN) tok_b.kind = KIND_LPAREN;
        else if (b == CH_RPAREN)     tok_b.kind = KIND_RPAREN;
        else if (b == CH_LBRACE)     tok_b.kind = KIND_LBRACE;
        else                         tok_b.kind = KIND_RBRACE;
      end else if (b == CH_QUOTE) begin
        pos_next       = pos_inc;
        tok_begin_next = pos_inc;  // body starts after the quote
        mode_next      = MODE_STRING;
      end else if (is_letter(b)) begin
        tok_begin_next = pos;
        cand_next      = kw_narrow('1, 3'd0, 1'b1, b);
        pos_next       = pos_inc;
        mode_next      = MODE_IDENT;
      end else begin
        b_vld    = 1'b1;           // unknown byte, tok_b.kind default
        pos_next = pos_inc;
      end
    end

    // last_of_run on the final token of this byte
    if (b_vld) begin
      tok_b.last = 1'b1;
    end else begin
      tok_a.last = 1'b1;
    end
  end

  assign n_push = {1'b0, a_vld} + {1'b0, b_vld};
  assign push   = s_axis_tvalid && s_axis_tready;
  assign pop    = m_axis_tvalid && m_axis_tready;

  assign s_axis_tready = (count <= 3'd2);
  assign m_axis_tvalid = (count != 3'd0);
  assign head          = fifo[rd_ptr];
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, head.line, head.length, head.start, head.kind};
  assign m_axis_tlast  = head.last;

  // Scanner state and queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      pos       <= '0;
      line_num  <= LINE_ONE;
      tok_begin <= '0;
      cand      <= '1;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
    end else begin
      if (push) begin
        mode      <= mode_next;
        pos       <= pos_next;
        line_num  <= line_next;
        tok_begin <= tok_begin_next;
        cand      <= cand_next;
        wr_ptr    <= wr_ptr + n_push;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + (push ? 3'(n_push) : 3'd0) - (pop ? 3'd1 : 3'd0);
    end
  end

  // Token queue storage
  always_ff @(posedge clk) begin
    if (push && a_vld) begin
      fifo[wr_ptr] <= tok_a;
    end
    if (push && b_vld) begin
      fifo[wr_ptr + {1'b0, a_vld}] <= tok_b;
    end
  end

endmodule

// File: rtl/core/kwtok_checker.sv
// Port-level checker for the keyword tokenizer, bound to the top level.
`timescale 1ns / 1ps

module kwtok_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [kwtok_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                              m_axis_tlast
);
  import kwtok_pkg::*;

  logic [KIND_W-1:0] kind;
  logic              no_text;

  assign kind    = m_axis_tdata[KIND_W-1:0];
  assign no_text = kind == KIND_END || kind == KIND_LPAREN || kind == KIND_RPAREN ||
                   kind == KIND_LBRACE || kind == KIND_RBRACE || kind == KIND_UNKNOWN;

  // Queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("token output valid right after reset");

  // Stalled token holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled token changed");

  // Kind stays in the defined range
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> kind <= KIND_UNKNOWN)
    else $error("token kind out of range");

  // Tokens without text carry zero start and length
  a_no_text: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && no_text |-> m_axis_tdata[KIND_W + 2*TEXT_W - 1:KIND_W] == '0)
    else $error("textless token carries text fields");

  // End token is always the final token of its byte
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && kind == KIND_END |-> m_axis_tlast)
    else $error("end token without tlast");

endmodule

bind keyword_tokenizer_core kwtok_checker u_kwtok_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
